@@ src/cba_pkg.sv @@
// Package for the contiguous block allocator: table sizes, actions, status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package cba_pkg;
  localparam int MaxBlocks = 16;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = $clog2(MaxBlocks + 1);
  localparam int AddrW = 16;
  localparam int IdW = 8;
  localparam int StW = 3;

  typedef enum logic [1:0] {
    ACT_FIRST = 2'd0, ACT_BEST = 2'd1, ACT_FREE = 2'd2, ACT_COMPACT = 2'd3
  } action_t;

  typedef enum logic [StW-1:0] {
    ST_OK = 3'd0, ST_OVERFLOW = 3'd1, ST_DUPLICATE = 3'd2,
    ST_NO_HOLE = 3'd3, ST_NOT_FOUND = 3'd4, ST_FULL = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_OUT
  } state_t;

  typedef struct packed {
    logic load;     // latch request, clear scan pointer
    logic scan;     // evaluate entry at pointer, advance
    logic decide;   // latch result status
    logic shift;    // one move/compact step at pointer
    logic commit;   // finish: write entry, count, free amount
  } cmd_t;

  typedef struct packed {
    logic scan_last;  // pointer at final hole index
    logic shift_done; // no more move steps
    logic fail;       // request fails, no table change
  } sts_t;
endpackage
`default_nettype wire

@@ src/cba_ctrl.sv @@
// Controller state machine for the contiguous block allocator.
// Depends on cba_pkg.
`default_nettype none
module cba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          out_fire,
  input  cba_pkg::sts_t      sts,
  output cba_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_valid
);
  cba_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cba_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      cba_pkg::S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = cba_pkg::S_SCAN;
        end
      end
      cba_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = cba_pkg::S_DECIDE;
      end
      cba_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.fail) state_nxt = cba_pkg::S_OUT;
        else state_nxt = cba_pkg::S_SHIFT;
      end
      cba_pkg::S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.commit = 1'b1;
          state_nxt = cba_pkg::S_OUT;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      cba_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) state_nxt = cba_pkg::S_IDLE;
      end
      default: state_nxt = cba_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ src/cba_dp.sv @@
// Datapath for the contiguous block allocator: block table, hole scan,
// entry moves and compaction. Depends on cba_pkg.
`default_nettype none
module cba_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [cba_pkg::AddrW-1:0]   cfg_wdata,
  input  wire logic [1:0]                  in_action,
  input  wire logic [cba_pkg::IdW-1:0]     in_block_id,
  input  wire logic [cba_pkg::AddrW-1:0]   in_block_size,
  input  cba_pkg::cmd_t                    cmd,
  output cba_pkg::sts_t                    sts,
  output logic [cba_pkg::StW-1:0]          res_status,
  output logic [cba_pkg::AddrW-1:0]        res_addr,
  output logic [cba_pkg::AddrW-1:0]        res_free
);
  localparam int AW = cba_pkg::AddrW;
  localparam int IW = cba_pkg::IdxW;
  localparam int CW = cba_pkg::CntW;

  logic [cba_pkg::IdW-1:0] id_mem [cba_pkg::MaxBlocks];
  logic [AW-1:0] st_mem [cba_pkg::MaxBlocks];
  logic [AW-1:0] en_mem [cba_pkg::MaxBlocks];

  logic [AW-1:0] mem_size_r, free_r;
  logic [CW-1:0] count_r, ptr_r;
  logic [1:0] act_r;
  logic [cba_pkg::IdW-1:0] id_r;
  logic [AW-1:0] size_r;
  logic dup_r, found_r;
  logic [CW-1:0] pos_r;
  logic [AW-1:0] best_r, lo_r, next_r;
  logic [AW-1:0] addr_r, flen_r;

  logic [IW-1:0] pidx, pidx_m1;
  logic [AW-1:0] hole_lo, hole_hi, hole_len, ent_len;
  logic in_tab, fits, take;
  logic [cba_pkg::StW-1:0] status;

  assign pidx = ptr_r[IW-1:0];
  assign pidx_m1 = pidx - IW'(1);
  assign in_tab = ptr_r < count_r;
  assign hole_lo = (ptr_r == '0) ? '0 : en_mem[pidx_m1];
  assign hole_hi = in_tab ? st_mem[pidx] : mem_size_r;
  assign hole_len = (hole_hi > hole_lo) ? hole_hi - hole_lo : '0;
  assign ent_len = (en_mem[pidx] >= st_mem[pidx]) ? en_mem[pidx] - st_mem[pidx] : '0;
  assign fits = size_r <= hole_len;
  assign take = fits && (act_r == cba_pkg::ACT_FIRST ? !found_r
                                                     : (!found_r || hole_len < best_r));

  always_comb begin
    if (act_r == cba_pkg::ACT_FIRST || act_r == cba_pkg::ACT_BEST) begin
      if (size_r > free_r) status = cba_pkg::ST_OVERFLOW;
      else if (dup_r) status = cba_pkg::ST_DUPLICATE;
      else if (count_r == CW'(cba_pkg::MaxBlocks)) status = cba_pkg::ST_FULL;
      else if (!found_r) status = cba_pkg::ST_NO_HOLE;
      else status = cba_pkg::ST_OK;
    end else if (act_r == cba_pkg::ACT_FREE) begin
      status = found_r ? cba_pkg::ST_OK : cba_pkg::ST_NOT_FOUND;
    end else begin
      status = cba_pkg::ST_OK;
    end
  end

  assign sts.fail = status != cba_pkg::ST_OK;
  assign sts.scan_last = (act_r == cba_pkg::ACT_COMPACT) || (ptr_r == count_r);
  assign sts.shift_done =
    (act_r == cba_pkg::ACT_FIRST || act_r == cba_pkg::ACT_BEST) ? (ptr_r <= pos_r) :
    (act_r == cba_pkg::ACT_FREE) ? (ptr_r + CW'(1) >= count_r) : (ptr_r >= count_r);

  // Control/bookkeeping registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= '0;
      free_r <= '0;
      count_r <= '0;
    end else if (cfg_we) begin
      mem_size_r <= cfg_wdata;
      free_r <= cfg_wdata;
      count_r <= '0;
    end else if (cmd.commit) begin
      if (act_r == cba_pkg::ACT_FIRST || act_r == cba_pkg::ACT_BEST) begin
        count_r <= count_r + CW'(1);
        free_r <= free_r - size_r;
      end else if (act_r == cba_pkg::ACT_FREE) begin
        count_r <= count_r - CW'(1);
        free_r <= ({1'b0, free_r} + {1'b0, flen_r} > {1'b0, {AW{1'b1}}})
                  ? {AW{1'b1}} : free_r + flen_r;
      end
    end
  end

  // Scan and move sequencing
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_action;
      id_r <= in_block_id;
      size_r <= in_block_size;
      ptr_r <= '0;
      dup_r <= 1'b0;
      found_r <= 1'b0;
      pos_r <= '0;
      best_r <= '0;
      addr_r <= '0;
      flen_r <= '0;
      next_r <= '0;
    end else if (cmd.scan) begin
      if (act_r == cba_pkg::ACT_FREE) begin
        if (in_tab && !found_r && id_mem[pidx] == id_r) begin
          found_r <= 1'b1;
          pos_r <= ptr_r;
          flen_r <= ent_len;
        end
      end else if (act_r != cba_pkg::ACT_COMPACT) begin
        if (in_tab && id_mem[pidx] == id_r) dup_r <= 1'b1;
        if (take) begin
          found_r <= 1'b1;
          best_r <= hole_len;
          pos_r <= ptr_r;
          lo_r <= hole_lo;
        end
      end
      if (!sts.scan_last) ptr_r <= ptr_r + CW'(1);
      else if (act_r == cba_pkg::ACT_FIRST || act_r == cba_pkg::ACT_BEST) ptr_r <= count_r;
      else if (act_r == cba_pkg::ACT_FREE) ptr_r <= pos_r;
      else ptr_r <= '0;
    end else if (cmd.shift) begin
      if (act_r == cba_pkg::ACT_FIRST || act_r == cba_pkg::ACT_BEST) ptr_r <= ptr_r - CW'(1);
      else ptr_r <= ptr_r + CW'(1);
      if (act_r == cba_pkg::ACT_COMPACT) next_r <= next_r + ent_len;
    end else if (cmd.commit) begin
      if ((act_r == cba_pkg::ACT_FIRST || act_r == cba_pkg::ACT_BEST)) addr_r <= lo_r;
    end
  end

  // Table writes
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      unique case (act_r)
        cba_pkg::ACT_FIRST, cba_pkg::ACT_BEST: begin
          id_mem[pidx] <= id_mem[pidx_m1];
          st_mem[pidx] <= st_mem[pidx_m1];
          en_mem[pidx] <= en_mem[pidx_m1];
        end
        cba_pkg::ACT_FREE: begin
          id_mem[pidx] <= id_mem[IW'(pidx + IW'(1))];
          st_mem[pidx] <= st_mem[IW'(pidx + IW'(1))];
          en_mem[pidx] <= en_mem[IW'(pidx + IW'(1))];
        end
        default: begin
          st_mem[pidx] <= next_r;
          en_mem[pidx] <= next_r + ent_len;
        end
      endcase
    end else if (cmd.commit && (act_r == cba_pkg::ACT_FIRST || act_r == cba_pkg::ACT_BEST)) begin
      id_mem[pidx] <= id_r;
      st_mem[pidx] <= lo_r;
      en_mem[pidx] <= lo_r + size_r;
    end
  end

  // status fixed at the decision, before the commit moves count and free amount
  logic [cba_pkg::StW-1:0] status_r;
  always_ff @(posedge clk) begin
    if (cmd.decide) status_r <= status;
  end

  assign res_status = status_r;
  assign res_addr = addr_r;
  assign res_free = free_r;
endmodule
`default_nettype wire

@@ src/contiguous_block_allocator.sv @@
// Contiguous block allocator, top level: controller and datapath.
// Depends on cba_pkg, cba_ctrl, cba_dp.
//
// One request at a time. A request scans the 16-entry table one entry per cycle,
// takes a decision step, then moves one entry per cycle to open or close a slot
// or to compact (up to 16 moves) and then commits; a failed request skips the
// moves and the commit. The result is held on out_ until taken; the next request
// is accepted once it is. The user must write memory_size through cfg_ only while
// idle; the block does not enforce this. A write empties the table.
`default_nettype none
module contiguous_block_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // action[1:0], block_id[9:2], block_size[25:10]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // status[2:0], start_address[18:3], free_remaining[34:19]
);
  cba_pkg::cmd_t cmd;
  cba_pkg::sts_t sts;
  logic busy;
  logic [cba_pkg::StW-1:0] st;
  logic [cba_pkg::AddrW-1:0] addr, fr;

  assign in_tready = !busy;

  cba_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_tvalid && in_tready),
    .out_fire(out_tvalid && out_tready),
    .sts, .cmd, .busy, .out_valid(out_tvalid)
  );

  cba_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_action(in_tdata[1:0]),
    .in_block_id(in_tdata[9:2]),
    .in_block_size(in_tdata[25:10]),
    .cmd, .sts,
    .res_status(st), .res_addr(addr), .res_free(fr)
  );

  assign out_tdata = {5'd0, fr, addr, st};

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.decide, cmd.shift, cmd.commit}))
    else $error("cmd overlap");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !out_tvalid)
    else $error("load while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
endmodule
`default_nettype wire

@@ bench/cba_checker.sv @@
// Checker for the contiguous block allocator: watches the request and result
// channels and the memory_size port, predicts each result, compares fields.
// Depends on cba_pkg.
`timescale 1ns / 100ps
`default_nettype none
module cba_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [31:0] in_tdata,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  output int               fail_count,
  output int               pending
);
  // lowest field last, to match the packing on out_tdata
  typedef struct packed {
    logic [cba_pkg::AddrW-1:0] free_remaining;
    logic [cba_pkg::AddrW-1:0] start_address;
    cba_pkg::status_t          status;
  } alloc_result_t;

  logic [15:0]               mem_size;
  logic [cba_pkg::IdW-1:0]   tbl_id[cba_pkg::MaxBlocks];
  logic [cba_pkg::AddrW-1:0] tbl_lo[cba_pkg::MaxBlocks];
  logic [cba_pkg::AddrW-1:0] tbl_hi[cba_pkg::MaxBlocks];
  int                        tbl_cnt;
  logic [16:0]               free_amt;
  alloc_result_t             expected_q[$];

  assign pending = expected_q.size();

  function automatic int gap_lo(int i);
    return (i == 0) ? 0 : int'(tbl_hi[i-1]);
  endfunction

  function automatic int gap_len(int i);
    int lo;
    int hi;
    lo = gap_lo(i);
    hi = (i < tbl_cnt) ? int'(tbl_lo[i]) : int'(mem_size);
    return (hi > lo) ? hi - lo : 0;
  endfunction

  task automatic apply_request(logic [31:0] d);
    cba_pkg::action_t act;
    logic [7:0]       id;
    logic [15:0]      sz;
    alloc_result_t    r;
    bit               dup;
    bit               found;
    int               pos;
    int               best;
    int               len;
    int               nxt;
    act = cba_pkg::action_t'(d[1:0]);
    id = d[9:2];
    sz = d[25:10];
    r.status = cba_pkg::ST_OK;
    r.start_address = '0;
    dup = 0;
    found = 0;
    pos = 0;
    best = 0;
    if (act == cba_pkg::ACT_FIRST || act == cba_pkg::ACT_BEST) begin
      for (int i = 0; i < tbl_cnt; i++) if (tbl_id[i] == id) dup = 1;
      if (sz > free_amt) r.status = cba_pkg::ST_OVERFLOW;
      else if (dup) r.status = cba_pkg::ST_DUPLICATE;
      else if (tbl_cnt >= cba_pkg::MaxBlocks) r.status = cba_pkg::ST_FULL;
      else begin
        for (int i = 0; i <= tbl_cnt; i++) begin
          len = gap_len(i);
          if (sz <= len) begin
            if (act == cba_pkg::ACT_FIRST) begin
              if (!found) begin
                found = 1;
                pos = i;
              end
            end else if (!found || len < best) begin
              found = 1;
              best = len;
              pos = i;
            end
          end
        end
        if (!found) r.status = cba_pkg::ST_NO_HOLE;
        else begin
          r.start_address = 16'(gap_lo(pos));
          for (int k = tbl_cnt; k > pos; k--) begin
            tbl_id[k] = tbl_id[k-1];
            tbl_lo[k] = tbl_lo[k-1];
            tbl_hi[k] = tbl_hi[k-1];
          end
          tbl_id[pos] = id;
          tbl_lo[pos] = r.start_address;
          tbl_hi[pos] = r.start_address + sz;
          tbl_cnt++;
          free_amt = free_amt - sz;
        end
      end
    end else if (act == cba_pkg::ACT_FREE) begin
      for (int i = 0; i < tbl_cnt; i++) if (!found && tbl_id[i] == id) begin
        found = 1;
        pos = i;
      end
      if (!found) r.status = cba_pkg::ST_NOT_FOUND;
      else begin
        len = (tbl_hi[pos] >= tbl_lo[pos]) ? int'(tbl_hi[pos] - tbl_lo[pos]) : 0;
        for (int i = pos; i + 1 < tbl_cnt; i++) begin
          tbl_id[i] = tbl_id[i+1];
          tbl_lo[i] = tbl_lo[i+1];
          tbl_hi[i] = tbl_hi[i+1];
        end
        tbl_cnt--;
        free_amt = 17'(free_amt + len);
        if (free_amt > 17'hFFFF) free_amt = 17'hFFFF;
      end
    end else begin
      nxt = 0;
      for (int i = 0; i < tbl_cnt; i++) begin
        len = (tbl_hi[i] >= tbl_lo[i]) ? int'(tbl_hi[i] - tbl_lo[i]) : 0;
        tbl_lo[i] = 16'(nxt);
        tbl_hi[i] = 16'(nxt + len);
        nxt = int'(tbl_hi[i]);
      end
    end
    r.free_remaining = free_amt[15:0];
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    alloc_result_t got;
    if (!rst_n) begin
      mem_size = '0;
      tbl_cnt = 0;
      free_amt = '0;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        mem_size = cfg_wdata;
        free_amt = {1'b0, cfg_wdata};
        tbl_cnt = 0;
      end
      if (out_tvalid && out_tready) begin
        got = alloc_result_t'(out_tdata[34:0]);
        if (expected_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("unexpected result %h", out_tdata);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("mismatch: status %0d/%0d addr %0d/%0d free %0d/%0d (exp/act)",
                       want.status, got.status, want.start_address, got.start_address,
                       want.free_remaining, got.free_remaining);
          end
        end
      end
      if (in_tvalid && in_tready) apply_request(in_tdata);
    end
  end
endmodule
`default_nettype wire

@@ bench/contiguous_block_allocator_tb.sv @@
// Testbench top for the contiguous block allocator: clock, reset, request
// stimulus, result back-pressure and verdict. Depends on cba_pkg, cba_checker.
`timescale 1ns / 100ps
`default_nettype none
module contiguous_block_allocator_tb;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  int          fail_count;
  int          pending;
  int          cycle_cnt = 0;
  bit          hold_results = 0;
  logic [7:0]  live_ids[$];

  always #6 clk = ~clk;

  contiguous_block_allocator uut (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata
  );

  cba_checker chk (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .fail_count, .pending
  );

  function automatic int gap_cycles();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 900000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, and one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        hold_results = 0;
      end
      n = ($urandom_range(0, 3) == 0) ? gap_cycles() : 0;
      out_tready <= (n == 0);
      repeat (n) @(posedge clk);
    end
  end

  // tvalid stays high after an accept until a gap or a pause drops it
  task automatic send_request(cba_pkg::action_t act, logic [7:0] id, logic [15:0] sz,
                              bit gaps = 1);
    int n;
    n = gaps ? gap_cycles() : 0;
    if (n > 0) begin
      in_tvalid <= 0;
      repeat (n) @(posedge clk);
    end
    in_tdata <= {6'd0, sz, id, act};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (act <= cba_pkg::ACT_BEST) live_ids.push_back(id);
  endtask

  task automatic drain_and_configure(logic [15:0] sz);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_wdata <= sz;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    live_ids.delete();
  endtask

  function automatic logic [15:0] pick_size(logic [15:0] msz);
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'($urandom_range(0, 16'hFFFF));
      2: return msz;
      default: return 16'($urandom_range(0, (msz >> 3) + 1));
    endcase
  endfunction

  initial begin
    logic [15:0]      msz;
    logic [7:0]       id;
    cba_pkg::action_t act;
    int               r;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: empty memory, then extremes
    send_request(cba_pkg::ACT_FIRST, 8'd1, 16'd0);
    send_request(cba_pkg::ACT_FIRST, 8'd2, 16'd1);
    send_request(cba_pkg::ACT_FREE, 8'd9, 16'd0);
    drain_and_configure(16'hFFFF);
    send_request(cba_pkg::ACT_FIRST, 8'hFF, 16'hFFFF);
    send_request(cba_pkg::ACT_BEST, 8'hFF, 16'd0);
    send_request(cba_pkg::ACT_FREE, 8'hFF, 16'd0);
    send_request(cba_pkg::ACT_FIRST, 8'd10, 16'd100);
    send_request(cba_pkg::ACT_FIRST, 8'd11, 16'd50);
    send_request(cba_pkg::ACT_FIRST, 8'd12, 16'd100);
    send_request(cba_pkg::ACT_FIRST, 8'd13, 16'd30);
    send_request(cba_pkg::ACT_FREE, 8'd10, 16'd0);
    send_request(cba_pkg::ACT_FREE, 8'd12, 16'd0);
    send_request(cba_pkg::ACT_BEST, 8'd14, 16'd40);
    send_request(cba_pkg::ACT_FIRST, 8'd15, 16'd40);
    send_request(cba_pkg::ACT_BEST, 8'd16, 16'hFFF0);
    send_request(cba_pkg::ACT_COMPACT, 8'd0, 16'hAAAA);
    send_request(cba_pkg::ACT_FREE, 8'd0, 16'h5555);
    drain_and_configure(16'd20);
    for (int i = 0; i < 17; i++) send_request(cba_pkg::ACT_FIRST, 8'(i), 16'd1, 0);
    send_request(cba_pkg::ACT_FIRST, 8'd3, 16'd0);
    send_request(cba_pkg::ACT_FIRST, 8'd200, 16'd21);
    // random phases at several memory sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: msz = 16'd0;
        1: msz = 16'hFFFF;
        default: msz = 16'($urandom_range(16, 4000));
      endcase
      drain_and_configure(msz);
      for (int k = 0; k < 240; k++) begin
        if (ph == 2 && k == 50) begin
          hold_results = 1;
          for (int j = 0; j < 5; j++) send_request(cba_pkg::ACT_FIRST, 8'(j), 16'd1, 0);
        end
        if (ph == 3 && k == 100) begin
          in_tvalid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        r = $urandom_range(0, 19);
        if (r < 8) act = cba_pkg::ACT_FIRST;
        else if (r < 14) act = cba_pkg::ACT_BEST;
        else if (r < 19) act = cba_pkg::ACT_FREE;
        else act = cba_pkg::ACT_COMPACT;
        if (act == cba_pkg::ACT_FREE && live_ids.size() > 0 && $urandom_range(0, 4) != 0)
          id = live_ids[$urandom_range(0, live_ids.size() - 1)];
        else if ($urandom_range(0, 7) == 0) id = 8'($urandom_range(0, 255));
        else id = 8'($urandom_range(0, 23));
        send_request(act, id, pick_size(msz));
      end
    end
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
src/cba_pkg.sv
src/cba_ctrl.sv
src/cba_dp.sv
src/contiguous_block_allocator.sv
bench/cba_checker.sv
bench/contiguous_block_allocator_tb.sv
